@@ sv/assert_macros.svh @@
// Assertion macros used by the checker module of the encoder.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/dme_pkg.sv @@
// Shared types, codes and constants of the delta-modulation encoder.
// No dependencies; dme_if and the encoder modules refer to it by scoped names.
`default_nettype none

package dme_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 18;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned RAND_W   = 32;
  localparam int unsigned CFG_DW   = 7;
  localparam int unsigned CFG_AW   = 2;

  // Internal arithmetic widths
  localparam int unsigned CLIP_W  = 15;  // clipped sample, level * 256
  localparam int unsigned ERR_W   = 17;  // error in 1/256 level steps
  localparam int unsigned NOISE_W = 25;  // dither in Q.24
  localparam int unsigned SUM_W   = 32;  // shaping sum before the final doubling
  localparam int unsigned TGT_W   = 36;  // shaped target in Q.24

  // Level limits
  localparam logic [LEVEL_W-1:0] LVL_STEP   = 7'd2;
  localparam logic [LEVEL_W-1:0] LVL_UP_MAX = 7'd125;
  localparam logic [LEVEL_W-1:0] LVL_DN_MIN = 7'd2;
  localparam logic [LEVEL_W-1:0] LVL_CLIP   = 7'd126;
  localparam logic [LEVEL_W-1:0] LVL_TOP    = 7'd127;
  localparam logic [CLIP_W-1:0]  CLIP_MAX   = 15'd32256;

  // Shaping filter coefficients, Q1.15
  localparam int unsigned SIX_TAPS = 6;
  localparam logic signed [15:0] COEF_LP = -16'sd14336;
  localparam logic signed [15:0] COEF_HP = 16'sd14336;
  localparam logic signed [15:0] COEF_SIX [SIX_TAPS] = '{
    16'sd9830, -16'sd6554, -16'sd3277, -16'sd6554, -16'sd3277, 16'sd1311
  };

  // Register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_INIT_LEVEL = 2'd0,
    CFG_PAD_LEVEL  = 2'd1,
    CFG_DITHER     = 2'd2,
    CFG_SHAPING    = 2'd3
  } dme_cfg_e;

  typedef enum logic [1:0] {
    DITHER_OFF    = 2'd0,
    DITHER_RECT   = 2'd1,
    DITHER_TRI    = 2'd2,
    DITHER_TRI_HP = 2'd3
  } dme_dither_e;

  typedef enum logic [1:0] {
    SHAPE_FLAT = 2'd0,
    SHAPE_LP   = 2'd1,
    SHAPE_HP   = 2'd2,
    SHAPE_SIX  = 2'd3
  } dme_shape_e;

  // Per-cycle control from the datapath to the state-holding units
  typedef struct packed {
    logic step;   // a transaction moves into the result register
    logic first;  // that transaction opens a new stream
  } dme_ctrl_t;

endpackage

`default_nettype wire

@@ sv/dme_if.sv @@
// Valid/ready channel interfaces for the encoder's sample input and result output.
// Depends on dme_pkg for field widths.
`default_nettype none

interface dme_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dme_pkg::SAMPLE_W-1:0]   sample;
  logic                                  pad;
  logic                                  first;
  logic        [dme_pkg::RAND_W-1:0]     random_a;
  logic        [dme_pkg::RAND_W-1:0]     random_b;

  modport source (output valid, sample, pad, first, random_a, random_b, input ready);
  modport sink   (input valid, sample, pad, first, random_a, random_b, output ready);
endinterface

interface dme_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  bit_res;
  logic        [dme_pkg::LEVEL_W-1:0]    level;
  logic        [7:0]                     packed_byte;
  logic                                  byte_ready;

  modport source (output valid, bit_res, level, packed_byte, byte_ready, input ready);
  modport sink   (input valid, bit_res, level, packed_byte, byte_ready, output ready);
endinterface

`default_nettype wire

@@ sv/dpcm_delta_mod_encoder.sv @@
// Top level of the 1-bit delta-modulation encoder with dither and noise shaping.
// Depends on dme_pkg, dme_if, dme_dither and dme_shaper.
//
// Usage:
//   in_i carries one transaction per sample: an 18-bit target (level * 256),
//   a pad flag, a first flag that opens a stream, and two 32-bit random words.
//   out_o returns one transaction per sample: the delta bit, the new level,
//   the byte being packed (first bit in bit 0) and a flag when it is full.
//   The cfg_* port writes one of four registers per cycle: initial level, pad
//   level, dither mode, shaping mode; the user must write only while the block is idle, unenforced by the block.
// Timing:
//   A transaction is held in the input register, where the whole step
//   (dither, error filter, compare, level update) is done by combinational
//   logic, and is then loaded into the result register; throughput is one
//   sample per cycle while out_o is not stalled. The rate is set by the
//   feedback from the level and error history back into the compare.
// Reset and stall:
//   Reset loads the registers with 64, 64, 3, 3 and clears level, error
//   history, dither memory and packing. While out_o is stalled the result
//   holds; the input register still takes one more transaction behind it.
`default_nettype none

module dpcm_delta_mod_encoder #(
  parameter int unsigned ERROR_TAPS = 6
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  dme_in_if.sink                       in_i,
  dme_out_if.source                    out_o,
  input  wire                          cfg_we_i,
  input  wire [dme_pkg::CFG_AW-1:0]    cfg_idx_i,
  input  wire [dme_pkg::CFG_DW-1:0]    cfg_data_i
);

  // Configuration registers
  logic [dme_pkg::LEVEL_W-1:0] init_level_q, pad_level_q;
  dme_pkg::dme_dither_e        dither_mode_q;
  dme_pkg::dme_shape_e         shaping_mode_q;

  // Input register
  logic                                in_valid_q;
  logic signed [dme_pkg::SAMPLE_W-1:0] sample_q;
  logic                                pad_q, first_q;
  logic        [dme_pkg::RAND_W-1:0]   random_a_q, random_b_q;

  // Result register
  logic                        out_valid_q;
  logic                        bit_q;
  logic [dme_pkg::LEVEL_W-1:0] out_level_q;
  logic [7:0]                  byte_q;
  logic                        byte_ready_q;

  // Stream state
  logic [dme_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [7:0]                  acc_q, acc_d;
  logic [2:0]                  cnt_q, cnt_d;

  // Datapath
  logic                                 in_acc, advance;
  dme_pkg::dme_ctrl_t                   ctrl;
  logic [dme_pkg::LEVEL_W-1:0]          lvl_eff, pad_clip;
  logic [2:0]                           cnt_eff;
  logic [dme_pkg::CLIP_W-1:0]           clipped;
  logic signed [dme_pkg::NOISE_W-1:0]   noise;
  logic signed [dme_pkg::SUM_W-1:0]     shape_sum;
  logic signed [dme_pkg::TGT_W-1:0]     base, target, lvl_q24;
  logic signed [dme_pkg::ERR_W-1:0]     err_new;
  logic                                 bit_new;

  // Handshakes: advance when the result register is free or being taken
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_acc      = in_i.valid && in_i.ready;
  assign ctrl.step   = advance;
  assign ctrl.first  = first_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_level_q   <= 7'd64;
      pad_level_q    <= 7'd64;
      dither_mode_q  <= dme_pkg::DITHER_TRI_HP;
      shaping_mode_q <= dme_pkg::SHAPE_SIX;
    end else if (cfg_we_i) begin
      unique case (dme_pkg::dme_cfg_e'(cfg_idx_i))
        dme_pkg::CFG_INIT_LEVEL: init_level_q   <= cfg_data_i;
        dme_pkg::CFG_PAD_LEVEL:  pad_level_q    <= cfg_data_i;
        dme_pkg::CFG_DITHER:     dither_mode_q  <= dme_pkg::dme_dither_e'(cfg_data_i[1:0]);
        dme_pkg::CFG_SHAPING:    shaping_mode_q <= dme_pkg::dme_shape_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // Input register: hold until the step is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q   <= in_i.sample;
      pad_q      <= in_i.pad;
      first_q    <= in_i.first;
      random_a_q <= in_i.random_a;
      random_b_q <= in_i.random_b;
    end
  end

  // Dither and error-feedback units
  dme_dither u_dither (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .mode_i     (dither_mode_q),
    .random_a_i (random_a_q),
    .random_b_i (random_b_q),
    .noise_o    (noise)
  );

  dme_shaper #(
    .ERROR_TAPS (ERROR_TAPS)
  ) u_shaper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .mode_i (shaping_mode_q),
    .err_i  (err_new),
    .sum_o  (shape_sum)
  );

  // Clip the sample to 0..126 levels for the error term
  always_comb begin
    pad_clip = (pad_level_q == dme_pkg::LVL_TOP) ? dme_pkg::LVL_CLIP : pad_level_q;
    if (pad_q) begin
      clipped = {pad_clip, 8'd0};
    end else if (sample_q[dme_pkg::SAMPLE_W-1]) begin
      clipped = '0;
    end else if (sample_q[16:15] != 2'b00 || sample_q[14:0] > dme_pkg::CLIP_MAX) begin
      clipped = dme_pkg::CLIP_MAX;
    end else begin
      clipped = sample_q[14:0];
    end
  end

  // Shape the target and decide the bit
  always_comb begin
    lvl_eff = first_q ? init_level_q : level_q;
    base    = pad_q ? $signed({5'd0, pad_level_q, 24'd0})
                    : $signed({{2{sample_q[dme_pkg::SAMPLE_W-1]}}, sample_q, 16'd0});
    target  = base + dme_pkg::TGT_W'(noise)
                   - $signed({{3{shape_sum[dme_pkg::SUM_W-1]}}, shape_sum, 1'b0});
    lvl_q24 = $signed({5'd0, lvl_eff, 24'd0});
    bit_new = (target >= lvl_q24);
  end

  // Step the level by two within its limits and form the new error
  always_comb begin
    level_d = lvl_eff;
    if (bit_new) begin
      if (lvl_eff <= dme_pkg::LVL_UP_MAX) begin
        level_d = lvl_eff + dme_pkg::LVL_STEP;
      end
    end else if (lvl_eff >= dme_pkg::LVL_DN_MIN) begin
      level_d = lvl_eff - dme_pkg::LVL_STEP;
    end
    err_new = $signed({2'd0, level_d, 8'd0}) - $signed({2'd0, clipped});
  end

  // Pack bits LSB first
  always_comb begin
    cnt_eff          = first_q ? 3'd0 : cnt_q;
    acc_d            = (cnt_eff == 3'd0) ? 8'd0 : acc_q;
    acc_d[cnt_eff]   = bit_new;
    cnt_d            = cnt_eff + 3'd1;
  end

  // Advance stream state on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (advance) begin
      level_q <= level_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bit_q        <= bit_new;
      out_level_q  <= level_d;
      byte_q       <= acc_d;
      byte_ready_q <= (cnt_eff == 3'd7);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.bit_res     = bit_q;
  assign out_o.level       = out_level_q;
  assign out_o.packed_byte = byte_q;
  assign out_o.byte_ready  = byte_ready_q;

endmodule

`default_nettype wire

@@ sv/dme_dither.sv @@
// Dither generator: none, rectangular, triangular or high-passed triangular noise in Q.24.
// Holds the previous high-passed dither value; depends on dme_pkg.
`default_nettype none

module dme_dither (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire dme_pkg::dme_ctrl_t               ctrl_i,
  input  wire dme_pkg::dme_dither_e             mode_i,
  input  wire [dme_pkg::RAND_W-1:0]             random_a_i,
  input  wire [dme_pkg::RAND_W-1:0]             random_b_i,
  output logic signed [dme_pkg::NOISE_W-1:0]    noise_o
);

  logic signed [dme_pkg::NOISE_W-1:0] prev_q, prev_d;
  logic signed [dme_pkg::NOISE_W-1:0] prev_eff, rect, tri_n, tri_hp;
  logic        [dme_pkg::RAND_W:0]    rsum;
  logic        [23:0]                 rsum_hi;

  // Build the three noise shapes; subtracting 2^23 flips the top bit
  always_comb begin
    rect     = dme_pkg::NOISE_W'($signed({~random_a_i[31], random_a_i[30:8]}));
    rsum     = {1'b0, random_a_i} + {1'b0, random_b_i};
    rsum_hi  = rsum[32:9];
    tri_n    = dme_pkg::NOISE_W'($signed({~rsum_hi[23], rsum_hi[22:0]}));
    prev_eff = ctrl_i.first ? '0 : prev_q;
    tri_hp   = tri_n - (prev_eff >>> 1);
  end

  // Select by mode
  always_comb begin
    unique case (mode_i)
      dme_pkg::DITHER_OFF:    noise_o = '0;
      dme_pkg::DITHER_RECT:   noise_o = rect;
      dme_pkg::DITHER_TRI:    noise_o = tri_n;
      dme_pkg::DITHER_TRI_HP: noise_o = tri_hp;
      default:                noise_o = '0;
    endcase
  end

  // Remember the high-passed value; in the other modes a new stream clears it
  always_comb begin
    prev_d = prev_q;
    if (ctrl_i.step) begin
      if (mode_i == dme_pkg::DITHER_TRI_HP) begin
        prev_d = tri_hp;
      end else if (ctrl_i.first) begin
        prev_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/dme_shaper.sv @@
// Error-feedback shaper: history of recent quantisation errors and their weighted sum.
// Depends on dme_pkg for coefficients and widths.
`default_nettype none

module dme_shaper #(
  parameter int unsigned ERROR_TAPS = 6
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire dme_pkg::dme_ctrl_t               ctrl_i,
  input  wire dme_pkg::dme_shape_e              mode_i,
  input  wire signed [dme_pkg::ERR_W-1:0]       err_i,
  output logic signed [dme_pkg::SUM_W-1:0]      sum_o
);

  // Only the taps that the six-tap filter can reach are kept
  localparam int unsigned NTAP =
    (ERROR_TAPS < dme_pkg::SIX_TAPS) ? ERROR_TAPS : dme_pkg::SIX_TAPS;

  // Newest error first; errors are held in 1/256 level steps, so every
  // Q1.15 product shifted back to Q.24 is exact: sum * 2
  logic signed [dme_pkg::ERR_W-1:0] hist_q [NTAP];
  logic signed [dme_pkg::ERR_W-1:0] h_eff  [NTAP];
  logic signed [dme_pkg::SUM_W-1:0] acc_six, prod_one;

  // A new stream reads an empty history
  always_comb begin
    for (int i = 0; i < NTAP; i++) begin
      h_eff[i] = ctrl_i.first ? '0 : hist_q[i];
    end
  end

  // Weighted sum over the taps, each product formed at full sum width
  always_comb begin
    acc_six  = '0;
    for (int i = 0; i < NTAP; i++) begin
      acc_six = acc_six + dme_pkg::SUM_W'(h_eff[i]) * dme_pkg::COEF_SIX[i];
    end
    prod_one = dme_pkg::SUM_W'(h_eff[0]) * dme_pkg::COEF_HP;
    unique case (mode_i)
      dme_pkg::SHAPE_FLAT: sum_o = '0;
      dme_pkg::SHAPE_LP:   sum_o = -prod_one;
      dme_pkg::SHAPE_HP:   sum_o = prod_one;
      dme_pkg::SHAPE_SIX:  sum_o = acc_six;
      default:             sum_o = '0;
    endcase
  end

  // Shift in the newest error on every transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NTAP; i++) begin
        hist_q[i] <= '0;
      end
    end else if (ctrl_i.step) begin
      hist_q[0] <= err_i;
      for (int i = 1; i < NTAP; i++) begin
        hist_q[i] <= h_eff[i-1];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/dme_checker.sv @@
// Port-level checker for the delta-modulation encoder, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dme_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire       bit_res_i,
  input wire [6:0] level_i,
  input wire       byte_ready_i
);

  logic out_acc;

  // A result transaction taken this cycle
  assign out_acc = out_valid_i && out_ready_i;

  // A stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A result is on offer once an accepted sample has passed the input and result registers
  `ASSERT_NEXT(a_latency, clk_i, rst_ni, in_valid_i && in_ready_i, ##1 out_valid_i)

  // A full byte is never followed directly by another full byte
  `ASSERT_NEXT(a_byte_gap, clk_i, rst_ni, out_acc && byte_ready_i, !(out_valid_i && byte_ready_i))

  // An up step cannot end below two, a down step cannot end above 125
  `ASSERT_SAME(a_up_level, clk_i, rst_ni, out_valid_i && bit_res_i, level_i >= 7'd2)
  `ASSERT_SAME(a_dn_level, clk_i, rst_ni, out_valid_i && !bit_res_i, level_i <= 7'd125)

endmodule

bind dpcm_delta_mod_encoder dme_checker u_dme_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .bit_res_i    (out_o.bit_res),
  .level_i      (out_o.level),
  .byte_ready_i (out_o.byte_ready)
);

`default_nettype wire
